// ----- hdl/ntcrt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the NTC ratio temperature pipeline.
// No dependencies; used by every module under hdl.
package ntcrt_pkg;

    localparam int MV_W       = 12;
    localparam int CFG_W      = 20;
    localparam int BETA_W     = 14;
    localparam int T0_W       = 16;
    localparam int IDX_W      = 3;

    localparam int LOG_IN_W   = 33;
    localparam int LOG_EXP_W  = 6;
    localparam int LOG_FRAC   = 24;
    localparam int LOG_W      = LOG_EXP_W + LOG_FRAC;
    localparam int LOG_STAGES = LOG_FRAC + 1;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    localparam int D_W        = 32;
    localparam int PROD_W     = 62;
    localparam int LN_W       = 28;
    localparam int TL_W       = 44;
    localparam int DEN_W      = 45;
    localparam int NUM_W      = 57;
    localparam int REM_W      = 62;
    localparam int Q_W        = 17;
    localparam int DIV_STAGES = Q_W + 1;

    localparam logic signed [18:0] KELVIN_OFFSET = 19'sd27315;

    // Stage numbers of the main pipeline.
    localparam int ST_IN   = 0;
    localparam int ST_MUL  = 1;
    localparam int ST_N    = 2;
    localparam int ST_LOGQ = ST_N + LOG_STAGES;
    localparam int ST_D    = ST_LOGQ + 1;
    localparam int ST_PROD = ST_D + 1;
    localparam int ST_LN   = ST_PROD + 1;
    localparam int ST_TL   = ST_LN + 1;
    localparam int ST_DEN  = ST_TL + 1;
    localparam int ST_DIVQ = ST_DEN + DIV_STAGES;
    localparam int ST_OUT  = ST_DIVQ + 1;

    typedef enum logic [IDX_W-1:0] {
        REG_BOTTOM = 3'd0,
        REG_REF_TOP = 3'd1,
        REG_NOMINAL_R = 3'd2,
        REG_BETA = 3'd3,
        REG_NOMINAL_T = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic valid;
        logic bad;
        logic neg;
    } ctl_t;

endpackage

// ----- hdl/ntcrt_log2.sv -----
`timescale 1ns / 1ps
// Pipelined base-2 logarithm: msb position plus 24 fraction bits by squaring.
// Depends on ntcrt_pkg.
module ntcrt_log2
(
    input  logic                           clk,
    input  logic                           en,
    input  logic [ntcrt_pkg::LOG_IN_W-1:0] val,
    output logic [ntcrt_pkg::LOG_W-1:0]    res
);

    logic [31:0]                  m_reg   [0:ntcrt_pkg::LOG_FRAC];
    logic [ntcrt_pkg::LOG_W-1:0]  res_reg [0:ntcrt_pkg::LOG_FRAC];

    logic [ntcrt_pkg::LOG_EXP_W-1:0] e;
    logic [64:0]                      wide;
    logic [31:0]                      m_next;

    always_comb
    begin
        e = '0;
        for (int i = 1; i < ntcrt_pkg::LOG_IN_W; i++)
        begin
            if (val[i])
            begin
                e = ntcrt_pkg::LOG_EXP_W'(i);
            end
        end
        // Puts the msb at bit 31 of the mantissa; a 33-bit value loses its lsb.
        wide   = {32'b0, val} << (ntcrt_pkg::LOG_EXP_W'(32) - e);
        m_next = wide[32:1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0]   <= m_next;
            res_reg[0] <= {e, {ntcrt_pkg::LOG_FRAC{1'b0}}};
        end
    end

    for (genvar g = 1; g <= ntcrt_pkg::LOG_FRAC; g++)
    begin : g_sq
        logic [63:0] sq;
        logic [32:0] mm;
        logic [31:0] m_step;
        logic [ntcrt_pkg::LOG_W-1:0] r_step;

        always_comb
        begin
            sq     = 64'(m_reg[g-1]) * 64'(m_reg[g-1]);
            mm     = sq[63:31];
            r_step = res_reg[g-1];
            if (mm[32])
            begin
                m_step = mm[32:1];
                r_step[ntcrt_pkg::LOG_FRAC-g] = 1'b1;
            end
            else
            begin
                m_step = mm[31:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[g]   <= m_step;
                res_reg[g] <= r_step;
            end
        end
    end

    assign res = res_reg[ntcrt_pkg::LOG_FRAC];

endmodule

// ----- hdl/ntcrt_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider: rounded quotient of 17 bits plus overflow flag.
// Depends on ntcrt_pkg.
module ntcrt_div
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [ntcrt_pkg::NUM_W-1:0] num,
    input  logic [ntcrt_pkg::DEN_W-1:0] den,
    input  logic                        den_zero,
    output logic [ntcrt_pkg::Q_W-1:0]   quo,
    output logic                        ovf
);

    logic [ntcrt_pkg::REM_W-1:0] rem_reg [0:ntcrt_pkg::Q_W];
    logic [ntcrt_pkg::DEN_W-1:0] den_reg [0:ntcrt_pkg::Q_W];
    logic [ntcrt_pkg::Q_W-1:0]   q_reg   [0:ntcrt_pkg::Q_W];
    logic                        ovf_reg [0:ntcrt_pkg::Q_W];

    logic [ntcrt_pkg::REM_W-1:0] dividend;
    logic [ntcrt_pkg::REM_W-1:0] den_top;

    always_comb
    begin
        // Adding half the divisor turns the floor into round-to-nearest.
        dividend = ntcrt_pkg::REM_W'(num) + ntcrt_pkg::REM_W'(den >> 1);
        den_top  = ntcrt_pkg::REM_W'(den) << ntcrt_pkg::Q_W;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= dividend;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= den_zero || (dividend >= den_top);
        end
    end

    for (genvar g = 1; g <= ntcrt_pkg::Q_W; g++)
    begin : g_step
        localparam int K = ntcrt_pkg::Q_W - g;
        logic [ntcrt_pkg::REM_W-1:0] sub;
        logic [ntcrt_pkg::REM_W-1:0] rem_step;
        logic [ntcrt_pkg::Q_W-1:0]   q_step;

        always_comb
        begin
            sub      = ntcrt_pkg::REM_W'(den_reg[g-1]) << K;
            rem_step = rem_reg[g-1];
            q_step   = q_reg[g-1];
            if (rem_reg[g-1] >= sub)
            begin
                rem_step = rem_reg[g-1] - sub;
                q_step[K] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= rem_step;
                den_reg[g] <= den_reg[g-1];
                q_reg[g]   <= q_step;
                ovf_reg[g] <= ovf_reg[g-1];
            end
        end
    end

    assign quo = q_reg[ntcrt_pkg::Q_W];
    assign ovf = ovf_reg[ntcrt_pkg::Q_W];

endmodule

// ----- hdl/ntc_ratio_temperature.sv -----
`timescale 1ns / 1ps
// NTC thermistor temperature from two divider voltages via the beta equation.
// Depends on ntcrt_pkg, ntcrt_log2 and ntcrt_div.
//
//  port group | dir | beat contents
//  s_*        | in  | reading pair: ntc_millivolts, ref_millivolts
//  m_*        | out | temp_centi_celsius in tdata, temp_valid in tuser
//  cfg_*      | in  | register write, one per cycle with cfg_we
//
// One beat enters per cycle while s_tready is high; a result appears on m_* once its
// beat has passed through every stage, and can leave at the next edge.
// Most of the stages are the 24 squaring stages of the log unit and 17 divider stages.
// All stages advance together; a stall on m_tready holds every stage and drops
// s_tready in the same cycle, so nothing is lost or repeated.
// Reset clears the stage valid bits and loads the register defaults.
module ntc_ratio_temperature
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,  // [11:0] ntc_millivolts, [23:12] ref_millivolts
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,  // [15:0] temp_centi_celsius
    output logic [0:0]                  m_tuser,  // [0] temp_valid
    input  logic                        cfg_we,
    input  logic [ntcrt_pkg::IDX_W-1:0] cfg_index,
    input  logic [ntcrt_pkg::CFG_W-1:0] cfg_data
);

    localparam int MV_W = ntcrt_pkg::MV_W;

    logic en;
    ntcrt_pkg::ctl_t ctl_reg [0:ntcrt_pkg::ST_OUT];

    logic [ntcrt_pkg::CFG_W-1:0]  bottom_reg, ref_top_reg, nominal_r_reg;
    logic [ntcrt_pkg::BETA_W-1:0] beta_reg;
    logic [ntcrt_pkg::T0_W-1:0]   t0_reg;

    logic [29:0]                  tb_reg;
    logic [ntcrt_pkg::NUM_W-1:0]  num_reg;
    logic [20:0]                  b100_reg;

    logic [MV_W-1:0]  ntc_reg [0:ntcrt_pkg::ST_N];
    logic [MV_W-1:0]  ref0_reg;
    logic [32:0]      pa_reg;
    logic [31:0]      pb_reg;
    logic [ntcrt_pkg::LOG_IN_W-1:0] n_reg;
    logic             n_bad;
    logic signed [33:0] n_diff;

    logic [ntcrt_pkg::LOG_W-1:0] log_n, log_t, log_r;
    logic signed [ntcrt_pkg::D_W-1:0] d_val;
    logic [ntcrt_pkg::D_W-2:0]   dmag_reg;
    logic [ntcrt_pkg::PROD_W-1:0] prod_reg;
    logic [ntcrt_pkg::LN_W-1:0]  ln_reg;
    logic [ntcrt_pkg::TL_W-1:0]  tl_reg;
    logic signed [ntcrt_pkg::DEN_W:0] den_val;
    logic [ntcrt_pkg::DEN_W-1:0] denmag_reg;
    logic                        den_zero_reg;
    logic                        neg_next;

    logic [ntcrt_pkg::Q_W-1:0]   quo;
    logic                        ovf;
    logic signed [18:0]          cel;
    logic [15:0]                 temp_reg;
    logic                        tv_reg;
    logic [15:0]                 temp_next;

    assign en       = !ctl_reg[ntcrt_pkg::ST_OUT].valid || m_tready;
    assign s_tready = en;
    assign m_tvalid = ctl_reg[ntcrt_pkg::ST_OUT].valid;
    assign m_tdata  = temp_reg;
    assign m_tuser  = tv_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bottom_reg    <= 20'd3000;
            ref_top_reg   <= 20'd10000;
            nominal_r_reg <= 20'd10000;
            beta_reg      <= 14'd3380;
            t0_reg        <= 16'd29815;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ntcrt_pkg::REG_BOTTOM:    bottom_reg    <= cfg_data;
                ntcrt_pkg::REG_REF_TOP:   ref_top_reg   <= cfg_data;
                ntcrt_pkg::REG_NOMINAL_R: nominal_r_reg <= cfg_data;
                ntcrt_pkg::REG_BETA:      beta_reg      <= cfg_data[ntcrt_pkg::BETA_W-1:0];
                ntcrt_pkg::REG_NOMINAL_T: t0_reg        <= cfg_data[ntcrt_pkg::T0_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Terms that depend on configuration only; they settle long before use.
    always_ff @(posedge clk)
    begin
        tb_reg   <= 30'(t0_reg) * 30'(beta_reg);
        num_reg  <= ntcrt_pkg::NUM_W'(37'(tb_reg) * 37'd100) << 20;
        b100_reg <= 21'(beta_reg) * 21'd100;
    end

    // Stage valid, bad and neg bits; the bad flag marks beats that give temp_valid = 0.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= ntcrt_pkg::ST_OUT; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            ctl_reg[0].valid <= s_tvalid;
            ctl_reg[0].bad   <= (s_tdata[MV_W-1:0] == '0) || (s_tdata[2*MV_W-1:MV_W] == '0);
            ctl_reg[0].neg   <= 1'b0;
            for (int i = 1; i <= ntcrt_pkg::ST_OUT; i++)
            begin
                if (i != ntcrt_pkg::ST_N && i != ntcrt_pkg::ST_DEN)
                begin
                    ctl_reg[i] <= ctl_reg[i-1];
                end
            end
            ctl_reg[ntcrt_pkg::ST_N].valid   <= ctl_reg[ntcrt_pkg::ST_N-1].valid;
            ctl_reg[ntcrt_pkg::ST_N].bad     <= ctl_reg[ntcrt_pkg::ST_N-1].bad || n_bad;
            ctl_reg[ntcrt_pkg::ST_N].neg     <= ctl_reg[ntcrt_pkg::ST_N-1].neg;
            ctl_reg[ntcrt_pkg::ST_DEN].valid <= ctl_reg[ntcrt_pkg::ST_DEN-1].valid;
            ctl_reg[ntcrt_pkg::ST_DEN].bad   <= ctl_reg[ntcrt_pkg::ST_DEN-1].bad;
            ctl_reg[ntcrt_pkg::ST_DEN].neg   <= neg_next;
        end
    end

    always_comb
    begin
        n_diff = $signed({1'b0, pa_reg}) - $signed({2'b0, pb_reg});
        n_bad  = n_diff[33] || (n_diff == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ntc_reg[0] <= s_tdata[MV_W-1:0];
            ref0_reg   <= s_tdata[2*MV_W-1:MV_W];
            ntc_reg[1] <= ntc_reg[0];
            ntc_reg[2] <= ntc_reg[1];
            pa_reg     <= 33'(21'(ref_top_reg) + 21'(bottom_reg)) * 33'(ref0_reg);
            pb_reg     <= 32'(bottom_reg) * 32'(ntc_reg[0]);
            n_reg      <= n_diff[32:0];
        end
    end

    ntcrt_log2 u_log_n
    (
        .clk (clk),
        .en  (en),
        .val (n_reg),
        .res (log_n)
    );

    ntcrt_log2 u_log_t
    (
        .clk (clk),
        .en  (en),
        .val (ntcrt_pkg::LOG_IN_W'(ntc_reg[2])),
        .res (log_t)
    );

    ntcrt_log2 u_log_r
    (
        .clk (clk),
        .en  (en),
        .val (ntcrt_pkg::LOG_IN_W'(nominal_r_reg)),
        .res (log_r)
    );

    always_comb
    begin
        d_val = $signed(ntcrt_pkg::D_W'(log_n)) - $signed(ntcrt_pkg::D_W'(log_t))
              - $signed(ntcrt_pkg::D_W'(log_r));
    end

    // Stage registers from the log difference to the scaled log term tl_reg.
    logic neg_d, neg_p, neg_l, neg_t;
    logic [ntcrt_pkg::PROD_W-1:0] rounded;

    assign rounded = prod_reg + (ntcrt_pkg::PROD_W'(1) << 33);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_d    <= d_val[ntcrt_pkg::D_W-1];
            dmag_reg <= d_val[ntcrt_pkg::D_W-1] ? (ntcrt_pkg::D_W-1)'(-d_val)
                                                : d_val[ntcrt_pkg::D_W-2:0];
            neg_p    <= neg_d;
            prod_reg <= ntcrt_pkg::PROD_W'(dmag_reg) * ntcrt_pkg::PROD_W'(ntcrt_pkg::LN2_Q30);
            neg_l    <= neg_p;
            ln_reg   <= rounded[61:34];
            neg_t    <= neg_l;
            tl_reg   <= ntcrt_pkg::TL_W'(t0_reg) * ntcrt_pkg::TL_W'(ln_reg);
        end
    end

    always_comb
    begin
        if (neg_t)
        begin
            den_val = $signed({5'b0, b100_reg, 20'b0}) - $signed({2'b0, tl_reg});
        end
        else
        begin
            den_val = $signed({5'b0, b100_reg, 20'b0}) + $signed({2'b0, tl_reg});
        end
        neg_next = den_val[ntcrt_pkg::DEN_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            denmag_reg   <= neg_next ? ntcrt_pkg::DEN_W'(-den_val) : den_val[ntcrt_pkg::DEN_W-1:0];
            den_zero_reg <= (den_val == '0);
        end
    end

    ntcrt_div u_div
    (
        .clk      (clk),
        .en       (en),
        .num      (num_reg),
        .den      (denmag_reg),
        .den_zero (den_zero_reg),
        .quo      (quo),
        .ovf      (ovf)
    );

    always_comb
    begin
        cel = ctl_reg[ntcrt_pkg::ST_DIVQ].neg ? -$signed({2'b0, quo}) : $signed({2'b0, quo});
        cel = cel - ntcrt_pkg::KELVIN_OFFSET;
        if (ctl_reg[ntcrt_pkg::ST_DIVQ].bad)
        begin
            temp_next = '0;
        end
        else if (ovf)
        begin
            temp_next = ctl_reg[ntcrt_pkg::ST_DIVQ].neg ? 16'h8000 : 16'h7FFF;
        end
        else if (cel > 19'sd32767)
        begin
            temp_next = 16'h7FFF;
        end
        else if (cel < -19'sd32768)
        begin
            temp_next = 16'h8000;
        end
        else
        begin
            temp_next = cel[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp_reg <= temp_next;
            tv_reg   <= !ctl_reg[ntcrt_pkg::ST_DIVQ].bad;
        end
    end

endmodule
